// ===== rtl/dpd_pkg.sv =====
// Shared constants, register codes and types of the distance PID drive block.
`timescale 1ns / 1ps
`default_nettype none

package dpd_pkg;

    localparam int POS_W      = 24;
    localparam int FRAC_W     = 16;
    localparam int GAIN_W     = 24;
    localparam int PCT_W      = 7;
    localparam int TOL_W      = 16;
    localparam int DRIVE_W    = 16;
    localparam int ERR_W      = POS_W + 1;
    localparam int PROD_W     = GAIN_W + 1 + ERR_W;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int DPROD_W    = GAIN_W + 1 + DIFF_W;
    localparam int ILIM_W     = PCT_W + FRAC_W + 1;
    localparam int IACC_W     = PROD_W + 1;
    localparam int SUM_W      = DPROD_W + 2;
    localparam int DRIVE_SHIFT = FRAC_W - 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = (POS_W > GAIN_W) ? POS_W : GAIN_W;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_POSITION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I_DT       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D_PER_DT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_LIMIT  = 3'd6;

    localparam logic [PCT_W-1:0]  RST_SPEED_LIMIT    = 7'd100;
    localparam logic [TOL_W-1:0]  RST_TOLERANCE      = 16'd2;
    localparam logic [GAIN_W-1:0] RST_GAIN_P         = 24'd32768;
    localparam logic [GAIN_W-1:0] RST_GAIN_I_DT      = 24'd39;
    localparam logic [GAIN_W-1:0] RST_GAIN_D_PER_DT  = 24'd0;
    localparam logic [PCT_W-1:0]  RST_INTEGRAL_LIMIT = 7'd50;

    typedef struct packed {
        logic signed [POS_W-1:0] target_position;
        logic [PCT_W-1:0]        speed_limit;
        logic [TOL_W-1:0]        tolerance;
        logic [GAIN_W-1:0]       gain_p;
        logic [GAIN_W-1:0]       gain_i_dt;
        logic [GAIN_W-1:0]       gain_d_per_dt;
        logic [PCT_W-1:0]        integral_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [PROD_W-1:0]  p_prod;
        logic signed [PROD_W-1:0]  i_prod;
        logic signed [DPROD_W-1:0] d_prod;
        logic signed [ERR_W-1:0]   err;
        logic                      in_band;
        logic                      at_target;
        logic                      sign_flip;
        logic                      restart;
    } terms_t;

endpackage

`default_nettype wire

// ===== rtl/distance_pid_drive_top.sv =====
// Top level of the distance PID drive controller.
//
// Input channel (s_*): one transaction per control tick carrying the left and
// right encoder positions and a restart bit that clears the integral and the
// previous error before the tick is processed.
// Result channel (m_*): one transaction per input, in order, carrying the
// clamped drive value (signed percent Q8.8), the position error and the
// at-target flag.
// Configuration: cfg_wr_en/cfg_index/cfg_wr_data write registers 0 to 6; other
// indexes are ignored. Write only while no tick is in flight.
// Three register stages: error register (loaded at the accepting edge), product
// register (three parallel multipliers), result register. m_valid rises as the
// result register loads. Throughput is one transaction per cycle while m_ready
// is high; the integral loop closes within the last stage.
// When m_ready is low each stage keeps accepting until it holds a transaction,
// so up to three transactions are buffered before s_ready drops.
// Synchronous active-low reset empties the pipeline, clears the integral and
// previous error, and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module distance_pid_drive_top (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [dpd_pkg::POS_W-1:0]  s_left_position,
    input  wire logic signed [dpd_pkg::POS_W-1:0]  s_right_position,
    input  wire logic                              s_restart,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [dpd_pkg::DRIVE_W-1:0]     m_drive_value,
    output logic signed [dpd_pkg::ERR_W-1:0]       m_position_error,
    output logic                                   m_at_target,
    input  wire logic                              cfg_wr_en,
    input  wire logic [dpd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dpd_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

    dpd_pkg::cfg_t                     cfg;
    dpd_pkg::terms_t                   terms;
    logic                              err_valid;
    logic                              err_ready;
    logic signed [dpd_pkg::ERR_W-1:0]  err;
    logic                              err_restart;
    logic                              terms_valid;
    logic                              terms_ready;

    dpd_cfg u_cfg (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    dpd_error u_error (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_left_position  (s_left_position),
        .s_right_position (s_right_position),
        .s_restart        (s_restart),
        .target_position  (cfg.target_position),
        .err_valid        (err_valid),
        .err_ready        (err_ready),
        .err              (err),
        .err_restart      (err_restart)
    );

    dpd_terms u_terms (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .in_valid   (err_valid),
        .in_ready   (err_ready),
        .in_err     (err),
        .in_restart (err_restart),
        .out_valid  (terms_valid),
        .out_ready  (terms_ready),
        .terms      (terms)
    );

    dpd_integrate u_integrate (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .in_valid         (terms_valid),
        .in_ready         (terms_ready),
        .terms            (terms),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_drive_value    (m_drive_value),
        .m_position_error (m_position_error),
        .m_at_target      (m_at_target)
    );

endmodule

`default_nettype wire

// ===== rtl/dpd_cfg.sv =====
// Configuration register file of the distance PID drive block.
`timescale 1ns / 1ps
`default_nettype none

module dpd_cfg (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [dpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [dpd_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output dpd_pkg::cfg_t                       cfg
);

    dpd_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_position <= '0;
            cfg_reg.speed_limit     <= dpd_pkg::RST_SPEED_LIMIT;
            cfg_reg.tolerance       <= dpd_pkg::RST_TOLERANCE;
            cfg_reg.gain_p          <= dpd_pkg::RST_GAIN_P;
            cfg_reg.gain_i_dt       <= dpd_pkg::RST_GAIN_I_DT;
            cfg_reg.gain_d_per_dt   <= dpd_pkg::RST_GAIN_D_PER_DT;
            cfg_reg.integral_limit  <= dpd_pkg::RST_INTEGRAL_LIMIT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dpd_pkg::CFG_TARGET_POSITION:
                    cfg_reg.target_position <= $signed(cfg_wr_data[dpd_pkg::POS_W-1:0]);
                dpd_pkg::CFG_SPEED_LIMIT:
                    cfg_reg.speed_limit <= cfg_wr_data[dpd_pkg::PCT_W-1:0];
                dpd_pkg::CFG_TOLERANCE:
                    cfg_reg.tolerance <= cfg_wr_data[dpd_pkg::TOL_W-1:0];
                dpd_pkg::CFG_GAIN_P:
                    cfg_reg.gain_p <= cfg_wr_data[dpd_pkg::GAIN_W-1:0];
                dpd_pkg::CFG_GAIN_I_DT:
                    cfg_reg.gain_i_dt <= cfg_wr_data[dpd_pkg::GAIN_W-1:0];
                dpd_pkg::CFG_GAIN_D_PER_DT:
                    cfg_reg.gain_d_per_dt <= cfg_wr_data[dpd_pkg::GAIN_W-1:0];
                dpd_pkg::CFG_INTEGRAL_LIMIT:
                    cfg_reg.integral_limit <= cfg_wr_data[dpd_pkg::PCT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/dpd_error.sv =====
// Input stage: averages the encoders and registers the position error.
`timescale 1ns / 1ps
`default_nettype none

module dpd_error (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic signed [dpd_pkg::POS_W-1:0] s_left_position,
    input  wire logic signed [dpd_pkg::POS_W-1:0] s_right_position,
    input  wire logic                             s_restart,
    input  wire logic signed [dpd_pkg::POS_W-1:0] target_position,
    output logic                                  err_valid,
    input  wire logic                             err_ready,
    output logic signed [dpd_pkg::ERR_W-1:0]      err,
    output logic                                  err_restart
);

    logic                              valid_reg;
    logic signed [dpd_pkg::ERR_W-1:0]  err_reg;
    logic                              restart_reg;
    logic signed [dpd_pkg::POS_W:0]    pos_sum;
    logic signed [dpd_pkg::POS_W-1:0]  pos_avg;
    logic signed [dpd_pkg::ERR_W-1:0]  err_next;

    // floor((l + r) / 2): arithmetic drop of the low bit
    assign pos_sum  = {s_left_position[dpd_pkg::POS_W-1], s_left_position}
                    + {s_right_position[dpd_pkg::POS_W-1], s_right_position};
    assign pos_avg  = pos_sum[dpd_pkg::POS_W:1];
    assign err_next = {target_position[dpd_pkg::POS_W-1], target_position}
                    - {pos_avg[dpd_pkg::POS_W-1], pos_avg};

    assign s_ready = !valid_reg || err_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            err_reg     <= err_next;
            restart_reg <= s_restart;
        end
    end

    assign err_valid   = valid_reg;
    assign err         = err_reg;
    assign err_restart = restart_reg;

endmodule

`default_nettype wire

// ===== rtl/dpd_terms.sv =====
// Product stage: P, I and D products, tolerance tests and previous error.
`timescale 1ns / 1ps
`default_nettype none

module dpd_terms (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire dpd_pkg::cfg_t                    cfg,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic signed [dpd_pkg::ERR_W-1:0] in_err,
    input  wire logic                             in_restart,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output dpd_pkg::terms_t                       terms
);

    logic                               valid_reg;
    dpd_pkg::terms_t                    terms_reg;
    dpd_pkg::terms_t                    terms_next;
    logic signed [dpd_pkg::ERR_W-1:0]   prev_err_reg;
    logic signed [dpd_pkg::ERR_W-1:0]   prev_eff;
    logic signed [dpd_pkg::DIFF_W-1:0]  err_diff;
    logic signed [dpd_pkg::GAIN_W:0]    gp_s;
    logic signed [dpd_pkg::GAIN_W:0]    gi_s;
    logic signed [dpd_pkg::GAIN_W:0]    gd_s;
    logic [dpd_pkg::ERR_W-1:0]          err_abs;
    logic [dpd_pkg::ERR_W-1:0]          tol_x;
    logic                               load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    assign prev_eff = in_restart ? '0 : prev_err_reg;
    assign err_diff = {in_err[dpd_pkg::ERR_W-1], in_err}
                    - {prev_eff[dpd_pkg::ERR_W-1], prev_eff};

    assign gp_s = $signed({1'b0, cfg.gain_p});
    assign gi_s = $signed({1'b0, cfg.gain_i_dt});
    assign gd_s = $signed({1'b0, cfg.gain_d_per_dt});

    assign err_abs = in_err[dpd_pkg::ERR_W-1] ? $unsigned(-in_err) : $unsigned(in_err);
    assign tol_x   = {{(dpd_pkg::ERR_W-dpd_pkg::TOL_W){1'b0}}, cfg.tolerance};

    always_comb begin
        terms_next.p_prod    = gp_s * in_err;
        terms_next.i_prod    = gi_s * in_err;
        terms_next.d_prod    = gd_s * err_diff;
        terms_next.err       = in_err;
        terms_next.in_band   = err_abs < tol_x;
        terms_next.at_target = err_abs <= tol_x;
        terms_next.sign_flip = (in_err < 0 && prev_eff > 0) || (in_err > 0 && prev_eff < 0);
        terms_next.restart   = in_restart;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            prev_err_reg <= '0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (load) begin
                prev_err_reg <= in_err;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            terms_reg <= terms_next;
        end
    end

    assign out_valid = valid_reg;
    assign terms     = terms_reg;

endmodule

`default_nettype wire

// ===== rtl/dpd_integrate.sv =====
// Output stage: integral update with anti-windup, PID sum, clamp and result register.
`timescale 1ns / 1ps
`default_nettype none

module dpd_integrate (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire dpd_pkg::cfg_t                     cfg,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire dpd_pkg::terms_t                   terms,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [dpd_pkg::DRIVE_W-1:0]     m_drive_value,
    output logic signed [dpd_pkg::ERR_W-1:0]       m_position_error,
    output logic                                   m_at_target
);

    logic                                valid_reg;
    logic signed [dpd_pkg::DRIVE_W-1:0]  drive_reg;
    logic signed [dpd_pkg::ERR_W-1:0]    err_reg;
    logic                                at_target_reg;
    logic signed [dpd_pkg::ILIM_W-1:0]   integral_reg;
    logic signed [dpd_pkg::ILIM_W-1:0]   integral_next;
    logic signed [dpd_pkg::ILIM_W-1:0]   i_base;
    logic signed [dpd_pkg::IACC_W-1:0]   i_acc;
    logic signed [dpd_pkg::ILIM_W-1:0]   ilim;
    logic signed [dpd_pkg::IACC_W-1:0]   ilim_x;
    logic signed [dpd_pkg::ILIM_W-1:0]   i_clamped;
    logic signed [dpd_pkg::ILIM_W-1:0]   slim;
    logic signed [dpd_pkg::SUM_W-1:0]    slim_x;
    logic signed [dpd_pkg::SUM_W-1:0]    pid_sum;
    logic signed [dpd_pkg::SUM_W-1:0]    sum_clamped;
    logic signed [dpd_pkg::SUM_W-1:0]    sum_shifted;
    logic signed [dpd_pkg::DRIVE_W-1:0]  drive_next;
    logic signed [dpd_pkg::DRIVE_W-1:0]  drive_bound;
    logic                                load;

    assign in_ready = !valid_reg || m_ready;
    assign load     = in_valid && in_ready;

    assign i_base = terms.restart ? '0 : integral_reg;
    assign i_acc  = {{(dpd_pkg::IACC_W-dpd_pkg::ILIM_W){i_base[dpd_pkg::ILIM_W-1]}}, i_base}
                  + {terms.i_prod[dpd_pkg::PROD_W-1], terms.i_prod};
    assign ilim   = $signed({1'b0, cfg.integral_limit, {dpd_pkg::FRAC_W{1'b0}}});
    assign ilim_x = {{(dpd_pkg::IACC_W-dpd_pkg::ILIM_W){1'b0}}, ilim};

    always_comb begin
        if (terms.in_band) begin
            i_clamped = '0;
        end else if (i_acc > ilim_x) begin
            i_clamped = ilim;
        end else if (i_acc < -ilim_x) begin
            i_clamped = -ilim;
        end else begin
            i_clamped = i_acc[dpd_pkg::ILIM_W-1:0];
        end
    end

    assign slim    = $signed({1'b0, cfg.speed_limit, {dpd_pkg::FRAC_W{1'b0}}});
    assign slim_x  = {{(dpd_pkg::SUM_W-dpd_pkg::ILIM_W){1'b0}}, slim};
    assign pid_sum =
        {{(dpd_pkg::SUM_W-dpd_pkg::PROD_W){terms.p_prod[dpd_pkg::PROD_W-1]}}, terms.p_prod}
      + {{(dpd_pkg::SUM_W-dpd_pkg::ILIM_W){i_clamped[dpd_pkg::ILIM_W-1]}}, i_clamped}
      + {{(dpd_pkg::SUM_W-dpd_pkg::DPROD_W){terms.d_prod[dpd_pkg::DPROD_W-1]}}, terms.d_prod};

    always_comb begin
        if (pid_sum > slim_x) begin
            sum_clamped = slim_x;
        end else if (pid_sum < -slim_x) begin
            sum_clamped = -slim_x;
        end else begin
            sum_clamped = pid_sum;
        end
    end

    // arithmetic shift gives the floor into Q8.8
    assign sum_shifted = sum_clamped >>> dpd_pkg::DRIVE_SHIFT;
    assign drive_next  = sum_shifted[dpd_pkg::DRIVE_W-1:0];

    assign integral_next = (terms.in_band || terms.sign_flip) ? '0 : i_clamped;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= 1'b0;
            integral_reg <= '0;
        end else begin
            if (in_ready) begin
                valid_reg <= in_valid;
            end
            if (load) begin
                integral_reg <= integral_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            drive_reg     <= drive_next;
            err_reg       <= terms.err;
            at_target_reg <= terms.at_target;
        end
    end

    assign m_valid          = valid_reg;
    assign m_drive_value    = drive_reg;
    assign m_position_error = err_reg;
    assign m_at_target      = at_target_reg;

    assign drive_bound = $signed({1'b0, cfg.speed_limit, 8'b0});

    a_reset_clears_output: assert property (@(posedge aclk)
        !aresetn |=> !valid_reg)
        else $error("result valid after reset");

    a_integral_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && (terms.in_band || terms.sign_flip)) |=> integral_reg == '0)
        else $error("integral not cleared on tolerance or sign change");

    a_drive_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (drive_reg <= drive_bound && drive_reg >= -drive_bound))
        else $error("drive value outside speed limit");

endmodule

`default_nettype wire
